/* rtl/ppc_pkg.sv */
// shared types, codes and helpers for the perspective project and clip block
`default_nettype none
package ppc_pkg;
   localparam int WORD_W = 32;
   localparam int CSR_IDX_W = 4;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_HEIGHT = 2'd1;
   localparam logic [1:0] MODE_PIXEL  = 2'd2;
   localparam logic [1:0] MODE_WIDE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_CONTROL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ASPECT  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDE    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TOP     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM  = 4'd7;

   typedef struct packed {
      logic signed [WORD_W-1:0] px;
      logic signed [WORD_W-1:0] py;
      logic signed [WORD_W-1:0] pz;
      logic                     neg;
      logic                     zero;
      logic [WORD_W-1:0]        dmag;
   } point_type;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[WORD_W-1:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/perspective_project_and_clip.sv */
// perspective divide, viewport mapping and rectangle visibility, fully pipelined
//
// Takes one clip-space point per clock and returns one result per clock once the
// pipeline is full and the output is not stalled. The pipeline has an entry
// stage, one restoring-division stage per reciprocal bit (2*FRAC_BITS+1), then nine
// stages of multiply, scale, mapping and compare. The whole pipeline advances
// together whenever the output register is empty or taken, so a stall holds every
// stage in place. Configuration is read live and must only change while idle.
`default_nettype none
module perspective_project_and_clip #(
   parameter int PIXEL_WIDTH  = 640,
   parameter int PIXEL_HEIGHT = 480,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // point_x, point_y, point_z, point_w
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // norm_x, norm_y, norm_z, viewport x, viewport y, inside_mask, on_screen, pad
   output logic [167:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [ppc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]  csr_data
);
   localparam int W   = ppc_pkg::WORD_W;
   localparam int QW  = 2 * FRAC_BITS + 1;
   localparam int XW  = W + 2;
   localparam int PWB = $clog2((PIXEL_WIDTH > PIXEL_HEIGHT ? PIXEL_WIDTH : PIXEL_HEIGHT) + 1) + 1;
   localparam int VW  = XW + PWB;
   localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF = ONE >>> 1;
   localparam logic signed [PWB-1:0] PW_S = PWB'(PIXEL_WIDTH);
   localparam logic signed [PWB-1:0] PH_S = PWB'(PIXEL_HEIGHT);

   function automatic logic signed [63:0] scale_one(input logic signed [63:0] p);
      logic signed [63:0] adj;
      adj = p + ((p < 0) ? (ONE - 64'sd1) : 64'sd0);
      return adj >>> FRAC_BITS;
   endfunction

   function automatic logic signed [63:0] halve(input logic signed [VW-1:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      return (e + ((e < 0) ? 64'sd1 : 64'sd0)) >>> 1;
   endfunction

   // configuration
   logic [3:0]          ctrl_ff;
   logic signed [W-1:0] extent_ff, aspect_ff, wide_ff, left_ff, right_ff, top_ff, bottom_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= 4'd1;
         extent_ff <= W'(ONE);
         aspect_ff <= W'(ONE);
         wide_ff   <= W'(ONE);
         left_ff   <= '0;
         right_ff  <= W'(ONE);
         top_ff    <= '0;
         bottom_ff <= W'(ONE);
      end else if (csr_valid) begin
         case (csr_index)
            ppc_pkg::REG_CONTROL: ctrl_ff   <= csr_data[3:0];
            ppc_pkg::REG_EXTENT:  extent_ff <= csr_data;
            ppc_pkg::REG_ASPECT:  aspect_ff <= csr_data;
            ppc_pkg::REG_WIDE:    wide_ff   <= csr_data;
            ppc_pkg::REG_LEFT:    left_ff   <= csr_data;
            ppc_pkg::REG_RIGHT:   right_ff  <= csr_data;
            ppc_pkg::REG_TOP:     top_ff    <= csr_data;
            ppc_pkg::REG_BOTTOM:  bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [1:0] mode;
   logic       clamp, wide_on;
   assign mode    = ctrl_ff[1:0];
   assign clamp   = ctrl_ff[2];
   assign wide_on = ctrl_ff[3];

   // pipeline advance
   logic en;
   logic v9_ff;
   assign en         = !v9_ff || rsp_tready;
   assign req_tready = en;

   // entry stage
   logic                 v0_ff;
   ppc_pkg::point_type   p0_ff, p0_in;
   logic signed [W-1:0]  w_in;

   always_comb begin
      w_in        = req_tdata[127:96];
      p0_in.px    = req_tdata[31:0];
      p0_in.py    = req_tdata[63:32];
      p0_in.pz    = req_tdata[95:64];
      p0_in.neg   = w_in[W-1];
      p0_in.zero  = (w_in == '0);
      p0_in.dmag  = w_in[W-1] ? (~w_in + 1'b1) : w_in;
   end

   // reciprocal division stages, one quotient bit each
   logic [QW-1:0]      dv_ff;
   logic [W-1:0]       dr_ff [QW];
   logic [W-1:0]       dr_in [QW];
   logic [QW-1:0]      dq_ff [QW];
   logic [QW-1:0]      dq_in [QW];
   ppc_pkg::point_type dp_ff [QW];
   ppc_pkg::point_type dp_src [QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         logic [W:0]    t;
         logic [W-1:0]  prem;
         logic [QW-1:0] pq;
         logic          ge;
         dp_src[s] = (s == 0) ? p0_ff : dp_ff[(s == 0) ? 0 : s - 1];
         prem      = (s == 0) ? '0 : dr_ff[(s == 0) ? 0 : s - 1];
         pq        = (s == 0) ? '0 : dq_ff[(s == 0) ? 0 : s - 1];
         // the only numerator bit sits at the top quotient position
         t         = {prem, (s == 0)};
         ge        = (t >= {1'b0, dp_src[s].dmag});
         dr_in[s]  = ge ? W'(t - {1'b0, dp_src[s].dmag}) : t[W-1:0];
         dq_in[s]  = pq | (QW'(ge) << (QW - 1 - s));
      end
   end

   // stage r: signed, saturated reciprocal
   logic                v1_ff;
   logic signed [W-1:0] recip_ff, recip_in;
   logic signed [W-1:0] x1_ff, y1_ff, z1_ff;
   always_comb begin
      logic [63:0] q;
      q = 64'(dq_ff[QW-1]);
      if (dp_ff[QW-1].zero) begin
         recip_in = 32'sh7fffffff;
      end else if (!dp_ff[QW-1].neg) begin
         recip_in = (q > 64'd2147483647) ? 32'sh7fffffff : q[W-1:0];
      end else begin
         recip_in = (q > 64'd2147483648) ? 32'sh80000000 : (~q[W-1:0] + 1'b1);
      end
   end

   // stage 2: ndc products
   logic                v2_ff, rpos2_ff;
   logic signed [63:0]  mx2_ff, my2_ff, mz2_ff;

   // stage 3: ndc and range bits
   logic                v3_ff;
   logic signed [W-1:0] nx3_ff, ny3_ff, nz3_ff, nx3_in, ny3_in, nz3_in;
   logic [2:0]          mask3_ff, mask3_in;
   always_comb begin
      nx3_in   = ppc_pkg::sat32(scale_one(mx2_ff));
      ny3_in   = ppc_pkg::sat32(scale_one(my2_ff));
      nz3_in   = ppc_pkg::sat32(scale_one(mz2_ff));
      mask3_in = '0;
      if (rpos2_ff) begin
         mask3_in[0] = (64'(nx3_in) >= -ONE) && (64'(nx3_in) < ONE);
         mask3_in[1] = (64'(ny3_in) >= -ONE) && (64'(ny3_in) < ONE);
         mask3_in[2] = (nz3_in >= 0) && (!clamp || (64'(nz3_in) < ONE));
      end
   end

   // stage 4: mode products
   logic                v4_ff;
   logic signed [W-1:0] nx4_ff, ny4_ff, nz4_ff;
   logic [2:0]          mask4_ff;
   logic signed [63:0]  ax4_ff, ey4_ff;

   // stage 5: mode selection and offset
   logic                v5_ff;
   logic signed [W-1:0] nx5_ff, ny5_ff, nz5_ff;
   logic [2:0]          mask5_ff;
   logic signed [XW-1:0] xo5_ff, yo5_ff, xo5_in, yo5_in;
   always_comb begin
      logic signed [W-1:0] xs, ys;
      xs = (mode == ppc_pkg::MODE_WIDE) ? ppc_pkg::sat32(scale_one(ax4_ff)) : nx4_ff;
      ys = (mode == ppc_pkg::MODE_HEIGHT || mode == ppc_pkg::MODE_WIDE)
           ? ppc_pkg::sat32(scale_one(ey4_ff)) : ny4_ff;
      xo5_in = XW'(xs) + XW'(ONE);
      yo5_in = XW'(ONE) - XW'(ys);
   end

   // stage 6: pixel scaling
   logic                v6_ff;
   logic signed [W-1:0] nx6_ff, ny6_ff, nz6_ff;
   logic [2:0]          mask6_ff;
   logic signed [VW-1:0] vx6_ff, vy6_ff;

   // stage 7: halving and wide offset
   logic                v7_ff;
   logic signed [W-1:0] nx7_ff, ny7_ff, nz7_ff, sx7_ff, sy7_ff, d7_ff, sx7_in, sy7_in;
   logic [2:0]          mask7_ff;
   assign sx7_in = ppc_pkg::sat32(halve(vx6_ff));
   assign sy7_in = ppc_pkg::sat32(halve(vy6_ff));

   // stage 8: wide product
   logic                v8_ff;
   logic signed [W-1:0] nx8_ff, ny8_ff, nz8_ff, sx8_ff, sy8_ff;
   logic [2:0]          mask8_ff;
   logic signed [63:0]  wp8_ff;

   // stage 9: rescale and visibility, output register
   logic signed [W-1:0] nx9_ff, ny9_ff, nz9_ff, sx9_ff, sy9_ff, sx9_in;
   logic [2:0]          mask9_ff;
   logic                vis9_ff, vis9_in;
   always_comb begin
      logic hor;
      sx9_in = wide_on
               ? ppc_pkg::sat32(HALF + 64'(ppc_pkg::sat32(scale_one(wp8_ff))))
               : sx8_ff;
      hor = (left_ff < sx9_in) && (sx9_in < right_ff);
      if (wide_on) begin
         vis9_in = (mask8_ff == 3'd7) || ((mask8_ff[1:0] == 2'b11) && hor);
      end else begin
         vis9_in = (mask8_ff == 3'd7) && hor;
      end
      vis9_in = vis9_in && (top_ff < sy8_ff) && (sy8_ff < bottom_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         dv_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         dv_ff <= {dv_ff[QW-2:0], v0_ff};
         v1_ff <= dv_ff[QW-1];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= p0_in;
         for (int s = 0; s < QW; s++) begin
            dr_ff[s] <= dr_in[s];
            dq_ff[s] <= dq_in[s];
            dp_ff[s] <= dp_src[s];
         end

         recip_ff <= recip_in;
         x1_ff    <= dp_ff[QW-1].px;
         y1_ff    <= dp_ff[QW-1].py;
         z1_ff    <= dp_ff[QW-1].pz;

         rpos2_ff <= (recip_ff > 0);
         mx2_ff   <= 64'(recip_ff) * 64'(x1_ff);
         my2_ff   <= 64'(recip_ff) * 64'(y1_ff);
         mz2_ff   <= 64'(recip_ff) * 64'(z1_ff);

         nx3_ff   <= nx3_in;
         ny3_ff   <= ny3_in;
         nz3_ff   <= nz3_in;
         mask3_ff <= mask3_in;

         nx4_ff   <= nx3_ff;
         ny4_ff   <= ny3_ff;
         nz4_ff   <= nz3_ff;
         mask4_ff <= mask3_ff;
         ax4_ff   <= 64'(aspect_ff) * 64'(nx3_ff);
         ey4_ff   <= 64'(extent_ff) * 64'(ny3_ff);

         nx5_ff   <= nx4_ff;
         ny5_ff   <= ny4_ff;
         nz5_ff   <= nz4_ff;
         mask5_ff <= mask4_ff;
         xo5_ff   <= xo5_in;
         yo5_ff   <= yo5_in;

         nx6_ff   <= nx5_ff;
         ny6_ff   <= ny5_ff;
         nz6_ff   <= nz5_ff;
         mask6_ff <= mask5_ff;
         if (mode == ppc_pkg::MODE_PIXEL) begin
            vx6_ff <= VW'(xo5_ff) * VW'(PW_S);
            vy6_ff <= VW'(yo5_ff) * VW'(PH_S);
         end else begin
            vx6_ff <= VW'(xo5_ff);
            vy6_ff <= VW'(yo5_ff);
         end

         nx7_ff   <= nx6_ff;
         ny7_ff   <= ny6_ff;
         nz7_ff   <= nz6_ff;
         mask7_ff <= mask6_ff;
         sx7_ff   <= sx7_in;
         sy7_ff   <= sy7_in;
         d7_ff    <= ppc_pkg::sat32(64'(sx7_in) - HALF);

         nx8_ff   <= nx7_ff;
         ny8_ff   <= ny7_ff;
         nz8_ff   <= nz7_ff;
         mask8_ff <= mask7_ff;
         sx8_ff   <= sx7_ff;
         sy8_ff   <= sy7_ff;
         wp8_ff   <= 64'(d7_ff) * 64'(wide_ff);

         nx9_ff   <= nx8_ff;
         ny9_ff   <= ny8_ff;
         nz9_ff   <= nz8_ff;
         mask9_ff <= mask8_ff;
         sx9_ff   <= sx9_in;
         sy9_ff   <= sy8_ff;
         vis9_ff  <= vis9_in;
      end
   end

   assign rsp_tvalid = v9_ff;
   assign rsp_tdata  = {4'd0, vis9_ff, mask9_ff, sy9_ff, sx9_ff, nz9_ff, ny9_ff, nx9_ff};
endmodule
`default_nettype wire
